@@ rtl/vss_pkg.sv @@
// ----------------------------------------------------------------------------
// vss_pkg
// Shared types and constants for the vehicle startup sequencer.
// ----------------------------------------------------------------------------
package vss_pkg;

  localparam int TIMER_BITS_DEFAULT = 16;
  localparam int CFG_TICK_W         = 16;
  localparam int APB_DATA_W         = 32;
  localparam int APB_ADDR_W         = 5;
  localparam int REG_IDX_W          = 3;

  localparam logic [CFG_TICK_W-1:0] FIRST_ACK_DEFAULT = 16'd1500;
  localparam logic [CFG_TICK_W-1:0] RTD_ACK_DEFAULT   = 16'd8000;
  localparam logic [CFG_TICK_W-1:0] MC_START_DELAY    = 16'd1000;
  localparam logic [CFG_TICK_W-1:0] TSA_ACK_DEFAULT   = RTD_ACK_DEFAULT + MC_START_DELAY;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FIRST_ACK  = 3'd0,
    REG_TSA_ACK    = 3'd1,
    REG_RTD_ACK    = 3'd2,
    REG_SKIP_SAFE  = 3'd3,
    REG_SKIP_BRAKE = 3'd4,
    REG_SKIP_HB    = 3'd5,
    REG_SPARE6     = 3'd6,
    REG_SPARE7     = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_ACK1 = 3'd1,
    PH_ACK2 = 3'd2,
    PH_TSA  = 3'd3,
    PH_RTDW = 3'd4,
    PH_RTD  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    MSG_TSA   = 2'd0,
    MSG_RTD   = 2'd1,
    MSG_IDLE  = 2'd2,
    MSG_OTHER = 2'd3
  } msg_t;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_TSA  = 2'd1;
  localparam logic [1:0] MODE_RTD  = 2'd2;

  localparam logic [2:0] DASH_IDLE_IDLE = 3'd0;
  localparam logic [2:0] DASH_TSA_IDLE  = 3'd1;
  localparam logic [2:0] DASH_TSA_TSA   = 3'd2;
  localparam logic [2:0] DASH_RTD_TSA   = 3'd3;
  localparam logic [2:0] DASH_RTD_RTD   = 3'd4;

  typedef struct packed {
    logic       tsa_button;
    logic       rtd_button;
    logic       loop_closed;
    logic       brake_on;
    logic       acu_alive;
    logic       mc_alive;
    logic       ack_valid;
    logic [1:0] ack_code;
  } tick_t;

  typedef struct packed {
    logic [1:0] car_mode;
    logic [2:0] dash_code;
    logic       mc_enable;
    logic       inverter_enable;
    logic       ack_fail;
    logic       broadcast_start;
    logic       torque_mode_cmd;
  } result_t;

  typedef struct packed {
    logic [CFG_TICK_W-1:0] first_ack_ticks;
    logic [CFG_TICK_W-1:0] tsa_ack_ticks;
    logic [CFG_TICK_W-1:0] rtd_ack_ticks;
    logic                  skip_safety_check;
    logic                  skip_brake_check;
    logic                  skip_heartbeat_check;
  } cfg_t;

endpackage

@@ rtl/vss_regs.sv @@
// ----------------------------------------------------------------------------
// vss_regs
// APB register file holding the timeout and check-skip settings.
// ----------------------------------------------------------------------------
module vss_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [vss_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [vss_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [vss_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready,
  output vss_pkg::cfg_t                       cfg
);

  vss_pkg::reg_idx_t idx;
  logic              wr;

  assign idx    = vss_pkg::reg_idx_t'(paddr[vss_pkg::APB_ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_ack_ticks      <= vss_pkg::FIRST_ACK_DEFAULT;
      cfg.tsa_ack_ticks        <= vss_pkg::TSA_ACK_DEFAULT;
      cfg.rtd_ack_ticks        <= vss_pkg::RTD_ACK_DEFAULT;
      cfg.skip_safety_check    <= 1'b0;
      cfg.skip_brake_check     <= 1'b0;
      cfg.skip_heartbeat_check <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        vss_pkg::REG_FIRST_ACK:  cfg.first_ack_ticks <= pwdata[vss_pkg::CFG_TICK_W-1:0];
        vss_pkg::REG_TSA_ACK:    cfg.tsa_ack_ticks   <= pwdata[vss_pkg::CFG_TICK_W-1:0];
        vss_pkg::REG_RTD_ACK:    cfg.rtd_ack_ticks   <= pwdata[vss_pkg::CFG_TICK_W-1:0];
        vss_pkg::REG_SKIP_SAFE:  cfg.skip_safety_check    <= pwdata[0];
        vss_pkg::REG_SKIP_BRAKE: cfg.skip_brake_check     <= pwdata[0];
        vss_pkg::REG_SKIP_HB:    cfg.skip_heartbeat_check <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      vss_pkg::REG_FIRST_ACK:  prdata[vss_pkg::CFG_TICK_W-1:0] = cfg.first_ack_ticks;
      vss_pkg::REG_TSA_ACK:    prdata[vss_pkg::CFG_TICK_W-1:0] = cfg.tsa_ack_ticks;
      vss_pkg::REG_RTD_ACK:    prdata[vss_pkg::CFG_TICK_W-1:0] = cfg.rtd_ack_ticks;
      vss_pkg::REG_SKIP_SAFE:  prdata[0] = cfg.skip_safety_check;
      vss_pkg::REG_SKIP_BRAKE: prdata[0] = cfg.skip_brake_check;
      vss_pkg::REG_SKIP_HB:    prdata[0] = cfg.skip_heartbeat_check;
      default:                 prdata = '0;
    endcase
  end

endmodule

@@ rtl/vss_core.sv @@
// ----------------------------------------------------------------------------
// vss_core
// Tick input register, startup state machine with ack timer, result register.
// ----------------------------------------------------------------------------
module vss_core #(
  parameter int TIMER_BITS = vss_pkg::TIMER_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  vss_pkg::cfg_t    cfg,
  input  logic             tick_valid,
  output logic             tick_ready,
  input  vss_pkg::tick_t   tick,
  output logic             result_valid,
  input  logic             result_ready,
  output vss_pkg::result_t result
);

  localparam logic [31:0] TIMER_MAX =
    (TIMER_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << TIMER_BITS) - 32'd1);

  // input stage
  logic           in_valid;
  vss_pkg::tick_t in_reg;
  logic           advance;

  // state
  vss_pkg::phase_t        phase, phase_next;
  logic [TIMER_BITS-1:0]  wait_timer, wait_timer_next;
  logic [2:0]             dash_reg, dash_reg_next;
  logic                   drive_enable, drive_enable_next;

  // decoded item
  logic            loop_ok, brake_ok, hb_ok, start_ok, msg, timeout;
  vss_pkg::msg_t   code;
  vss_pkg::result_t res_next;

  function automatic logic [TIMER_BITS-1:0] sat_load(
    input logic [vss_pkg::CFG_TICK_W-1:0] v
  );
    logic [31:0] w;
    w = {{(32 - vss_pkg::CFG_TICK_W){1'b0}}, v};
    if (w > TIMER_MAX) begin
      w = TIMER_MAX;
    end
    return w[TIMER_BITS-1:0];
  endfunction

  assign advance    = in_valid && (!result_valid || result_ready);
  assign tick_ready = !in_valid || advance;

  assign loop_ok  = in_reg.loop_closed || cfg.skip_safety_check;
  assign brake_ok = in_reg.brake_on || cfg.skip_brake_check;
  assign hb_ok    = (in_reg.acu_alive && in_reg.mc_alive) || cfg.skip_heartbeat_check;
  assign start_ok = loop_ok && brake_ok && hb_ok;
  assign msg      = in_reg.ack_valid;
  assign code     = vss_pkg::msg_t'(in_reg.ack_code);
  assign timeout  = (wait_timer == '0) || (wait_timer == TIMER_BITS'(1));

  // next state
  always_comb begin
    phase_next        = phase;
    wait_timer_next   = wait_timer;
    dash_reg_next     = dash_reg;
    drive_enable_next = drive_enable;
    unique case (phase)
      vss_pkg::PH_ACK1, vss_pkg::PH_ACK2: begin
        if (msg) begin
          if (code != vss_pkg::MSG_TSA) begin
            phase_next        = vss_pkg::PH_IDLE;
            wait_timer_next   = '0;
            dash_reg_next     = vss_pkg::DASH_IDLE_IDLE;
            drive_enable_next = 1'b0;
          end else if (phase == vss_pkg::PH_ACK1) begin
            phase_next      = vss_pkg::PH_ACK2;
            dash_reg_next   = vss_pkg::DASH_TSA_IDLE;
            wait_timer_next = sat_load(cfg.tsa_ack_ticks);
          end else begin
            phase_next      = vss_pkg::PH_TSA;
            dash_reg_next   = vss_pkg::DASH_TSA_TSA;
            wait_timer_next = '0;
          end
        end else if (timeout) begin
          phase_next        = vss_pkg::PH_IDLE;
          wait_timer_next   = '0;
          dash_reg_next     = vss_pkg::DASH_IDLE_IDLE;
          drive_enable_next = 1'b0;
        end else begin
          wait_timer_next = wait_timer - TIMER_BITS'(1);
        end
      end
      vss_pkg::PH_TSA: begin
        if (!loop_ok || in_reg.tsa_button || (msg && code == vss_pkg::MSG_IDLE)) begin
          phase_next        = vss_pkg::PH_IDLE;
          wait_timer_next   = '0;
          dash_reg_next     = vss_pkg::DASH_IDLE_IDLE;
          drive_enable_next = 1'b0;
        end else if (in_reg.rtd_button && start_ok) begin
          phase_next      = vss_pkg::PH_RTDW;
          dash_reg_next   = vss_pkg::DASH_RTD_TSA;
          wait_timer_next = sat_load(cfg.rtd_ack_ticks);
        end
      end
      vss_pkg::PH_RTDW: begin
        if (msg) begin
          if (code != vss_pkg::MSG_RTD || in_reg.tsa_button) begin
            phase_next        = vss_pkg::PH_IDLE;
            wait_timer_next   = '0;
            dash_reg_next     = vss_pkg::DASH_IDLE_IDLE;
            drive_enable_next = 1'b0;
          end else begin
            phase_next        = vss_pkg::PH_RTD;
            dash_reg_next     = vss_pkg::DASH_RTD_RTD;
            drive_enable_next = 1'b1;
            wait_timer_next   = '0;
          end
        end else if (timeout || in_reg.tsa_button) begin
          phase_next        = vss_pkg::PH_IDLE;
          wait_timer_next   = '0;
          dash_reg_next     = vss_pkg::DASH_IDLE_IDLE;
          drive_enable_next = 1'b0;
        end else begin
          wait_timer_next = wait_timer - TIMER_BITS'(1);
        end
      end
      vss_pkg::PH_RTD: begin
        if (in_reg.rtd_button || in_reg.tsa_button || (msg && code == vss_pkg::MSG_IDLE) ||
            !hb_ok) begin
          phase_next        = vss_pkg::PH_IDLE;
          wait_timer_next   = '0;
          dash_reg_next     = vss_pkg::DASH_IDLE_IDLE;
          drive_enable_next = 1'b0;
        end
      end
      default: begin
        phase_next        = vss_pkg::PH_IDLE;
        wait_timer_next   = '0;
        dash_reg_next     = vss_pkg::DASH_IDLE_IDLE;
        drive_enable_next = 1'b0;
        if (in_reg.tsa_button && start_ok) begin
          phase_next      = vss_pkg::PH_ACK1;
          wait_timer_next = sat_load(cfg.first_ack_ticks);
        end
      end
    endcase
  end

  // result fields
  always_comb begin
    res_next                 = '0;
    res_next.dash_code       = dash_reg_next;
    res_next.mc_enable       = drive_enable_next;
    res_next.inverter_enable = drive_enable_next;
    unique case (phase_next)
      vss_pkg::PH_IDLE:                  res_next.car_mode = vss_pkg::MODE_IDLE;
      vss_pkg::PH_RTDW, vss_pkg::PH_RTD: res_next.car_mode = vss_pkg::MODE_RTD;
      default:                           res_next.car_mode = vss_pkg::MODE_TSA;
    endcase
    unique case (phase)
      vss_pkg::PH_ACK1, vss_pkg::PH_ACK2: begin
        res_next.ack_fail = msg ? (code != vss_pkg::MSG_TSA) : timeout;
      end
      vss_pkg::PH_RTDW: begin
        res_next.ack_fail        = msg ? (code != vss_pkg::MSG_RTD) : timeout;
        res_next.torque_mode_cmd = msg && (code == vss_pkg::MSG_RTD);
      end
      vss_pkg::PH_TSA, vss_pkg::PH_RTD: ;
      default: begin
        res_next.broadcast_start = in_reg.tsa_button && start_ok;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      result_valid <= 1'b0;
      phase        <= vss_pkg::PH_IDLE;
      wait_timer   <= '0;
      dash_reg     <= vss_pkg::DASH_IDLE_IDLE;
      drive_enable <= 1'b0;
    end else begin
      if (tick_valid && tick_ready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        result_valid <= 1'b1;
        phase        <= phase_next;
        wait_timer   <= wait_timer_next;
        dash_reg     <= dash_reg_next;
        drive_enable <= drive_enable_next;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_valid && tick_ready) begin
      in_reg <= tick;
    end
    if (advance) begin
      result <= res_next;
    end
  end

endmodule

@@ rtl/vehicle_startup_sequencer_top.sv @@
// ----------------------------------------------------------------------------
// vehicle_startup_sequencer_top
// Startup sequencer idle -> tractive active -> ready to drive, one tick a beat.
//
//   channel  handshake                  payload
//   tick     tick_valid / tick_ready    tick (vss_pkg::tick_t)
//   result   result_valid / result_ready result (vss_pkg::result_t)
//   config   psel / penable, pready=1   paddr, pwdata, prdata
//
// one result beat per tick beat, registered once the result register is free
// a tick beat can be taken every cycle while the result is not stalled: input
// register, then state update and result register in one pass
// a stalled result holds while one further tick waits in the input register
// rst is synchronous: idle phase, timer zero, registers to defaults
// ----------------------------------------------------------------------------
module vehicle_startup_sequencer_top #(
  parameter int TIMER_BITS = vss_pkg::TIMER_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           tick_valid,
  output logic                           tick_ready,
  input  vss_pkg::tick_t                 tick,
  output logic                           result_valid,
  input  logic                           result_ready,
  output vss_pkg::result_t               result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [vss_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [vss_pkg::APB_DATA_W-1:0] pwdata,
  output logic [vss_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  vss_pkg::cfg_t cfg;

  vss_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vss_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .tick_valid   (tick_valid),
    .tick_ready   (tick_ready),
    .tick         (tick),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
